### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

### rtl/core/ohm_pkg.sv
package ohm_pkg;

    // field widths
    localparam int REQ_W      = 2;
    localparam int KEY_W      = 64;
    localparam int HASH_W     = 32;
    localparam int MEMBER_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int ORDER_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int CFG_W      = 4;
    localparam int LOG2_W     = 5;
    localparam int HASH_SHIFT = 5;

    // packed stream widths
    localparam int IN_DATA_W  = KEY_W + HASH_W + MEMBER_W;
    localparam int OUT_DATA_W = MEMBER_W + ORDER_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_CHECK,
        S_REPLY
    } state_t;

endpackage

### rtl/core/open_addressing_hash_map.sv
// Open-addressing hash map with a perturbed probe sequence, up to
// 2**MAX_SLOTS_LOG2 slots held in one single-port synchronous memory.
// Requests arrive on the s_ stream (insert, lookup, clear) and each gives
// exactly one result on the m_ stream. Every probe is one memory read. An
// insert or lookup is taken in S_IDLE and probes slots in S_CHECK; no new
// request is taken until its result is finished. If a result finishes
// while the output register is still occupied, the block waits and takes
// no request until m_tready frees that register. A clear and the pass that
// follows reset both write all 2**MAX_SLOTS_LOG2 slots (256 at the default)
// once, and no request is accepted during the pass; a clear returns its
// result after that pass. size_log2 is written through the cfg port; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Inserts do not check for duplicate keys.
`include "assert_macros.svh"

module open_addressing_hash_map #(
    parameter int MAX_SLOTS_LOG2 = 8,
    parameter int KEY_BITS       = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ohm_pkg::CFG_W-1:0]         cfg_data,    // size_log2
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ohm_pkg::IN_DATA_W-1:0]     s_tdata,     // key, key_hash, member_ref
    input  logic [ohm_pkg::REQ_W-1:0]         s_tuser,     // req_type
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ohm_pkg::OUT_DATA_W-1:0]    m_tdata,     // found_member, found_order
    output logic [ohm_pkg::STATUS_W-1:0]      m_tuser      // status
);
    import ohm_pkg::*;

    localparam int AW     = MAX_SLOTS_LOG2;
    localparam int DEPTH  = 1 << AW;
    localparam int WORD_W = 1 + KEY_BITS + MEMBER_W + ORDER_W;

    // slot memory: used flag, key, member handle, insertion number
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    // control registers
    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   size_log2_reg;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic               sweep_reply_reg, sweep_reply_next;
    logic [AW:0]        probe_reg, probe_next;
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [MEMBER_W-1:0] member_reg, member_next;
    logic [AW-1:0]       bucket_reg, bucket_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [MEMBER_W-1:0] res_member_reg, res_member_next;
    logic [ORDER_W-1:0]  res_order_reg, res_order_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [MEMBER_W-1:0] out_member_reg, out_member_next;
    logic [ORDER_W-1:0]  out_order_reg, out_order_next;

    // probe arithmetic
    logic [AW-1:0] first_bucket;
    logic [AW-1:0] step_bucket;
    logic [AW:0]   slot_count;

    // finishing result
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [MEMBER_W-1:0] fin_member;
    logic [ORDER_W-1:0]  fin_order;
    logic                out_free;
    logic                accept;

    // fields of the word read back
    logic                slot_used;
    logic [KEY_BITS-1:0] slot_key;
    logic [MEMBER_W-1:0] slot_member;
    logic [ORDER_W-1:0]  slot_order;

    ohm_probe #(
        .MAX_SLOTS_LOG2 (MAX_SLOTS_LOG2)
    ) u_probe (
        .size_log2    (size_log2_reg),
        .key_hash     (s_tdata[KEY_W +: HASH_W]),
        .bucket       (bucket_reg),
        .hash_run     (hash_reg),
        .first_bucket (first_bucket),
        .next_bucket  (step_bucket),
        .slot_count   (slot_count)
    );

    assign slot_used   = rdata_reg[WORD_W-1];
    assign slot_key    = rdata_reg[WORD_W-2 -: KEY_BITS];
    assign slot_member = rdata_reg[ORDER_W +: MEMBER_W];
    assign slot_order  = rdata_reg[ORDER_W-1:0];

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_order_reg, out_member_reg};

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_log2_reg <= CFG_W'(2);
        else if (cfg_valid && cfg_ready)
            size_log2_reg <= cfg_data;
    end

    // slot memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // next state, memory control and result selection
    always_comb
    begin
        state_next       = state_reg;
        sweep_next       = sweep_reg;
        sweep_reply_next = sweep_reply_reg;
        probe_next       = probe_reg;
        entry_count_next = entry_count_reg;
        req_next         = req_reg;
        key_next         = key_reg;
        hash_next        = hash_reg;
        member_next      = member_reg;
        bucket_next      = bucket_reg;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = bucket_reg;
        mem_raddr = step_bucket;
        mem_wdata = {1'b1, key_reg, member_reg, entry_count_reg[ORDER_W-1:0]};

        fin        = 1'b0;
        fin_status = STAT_OK;
        fin_member = '0;
        fin_order  = '0;

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
                if (sweep_reg == '1)
                begin
                    if (sweep_reply_reg)
                        fin = 1'b1;
                    else
                        state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = s_tuser;
                    key_next    = s_tdata[KEY_BITS-1:0];
                    hash_next   = s_tdata[KEY_W +: HASH_W];
                    member_next = s_tdata[KEY_W+HASH_W +: MEMBER_W];
                    unique case (s_tuser) inside
                        REQ_INSERT, REQ_LOOKUP:
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = first_bucket;
                            bucket_next = first_bucket;
                            probe_next  = '0;
                            state_next  = S_CHECK;
                        end
                        REQ_CLEAR:
                        begin
                            entry_count_next = '0;
                            sweep_next       = '0;
                            sweep_reply_next = 1'b1;
                            state_next       = S_SWEEP;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if (!slot_used)
                begin
                    // empty slot ends both walks
                    fin = 1'b1;
                    if (req_reg == REQ_INSERT)
                    begin
                        mem_we           = 1'b1;
                        fin_order        = entry_count_reg[ORDER_W-1:0];
                        entry_count_next = entry_count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        fin_status = STAT_NOT_FOUND;
                    end
                end
                else if (req_reg == REQ_LOOKUP && slot_key == key_reg)
                begin
                    fin        = 1'b1;
                    fin_member = slot_member;
                    fin_order  = slot_order;
                end
                else if (probe_reg + (AW+1)'(1) == slot_count)
                begin
                    // probe budget spent
                    fin        = 1'b1;
                    fin_status = (req_reg == REQ_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
                end
                else
                begin
                    mem_re      = 1'b1;
                    bucket_next = step_bucket;
                    hash_next   = hash_reg >> HASH_SHIFT;
                    probe_next  = probe_reg + (AW+1)'(1);
                end
            end

            S_REPLY:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
            state_next = out_free ? S_IDLE : S_REPLY;
    end

    // output register and staged result
    always_comb
    begin
        res_status_next = res_status_reg;
        res_member_next = res_member_reg;
        res_order_next  = res_order_reg;
        out_status_next = out_status_reg;
        out_member_next = out_member_reg;
        out_order_next  = out_order_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (fin && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = fin_status;
            out_member_next = fin_member;
            out_order_next  = fin_order;
        end
        else if (fin)
        begin
            res_status_next = fin_status;
            res_member_next = fin_member;
            res_order_next  = fin_order;
        end
        else if (state_reg == S_REPLY && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_member_next = res_member_reg;
            out_order_next  = res_order_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            sweep_reg       <= '0;
            sweep_reply_reg <= 1'b0;
            probe_reg       <= '0;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            sweep_reply_reg <= sweep_reply_next;
            probe_reg       <= probe_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        hash_reg       <= hash_next;
        member_reg     <= member_next;
        bucket_reg     <= bucket_next;
        res_status_reg <= res_status_next;
        res_member_reg <= res_member_next;
        res_order_reg  <= res_order_next;
        out_status_reg <= out_status_next;
        out_member_reg <= out_member_next;
        out_order_reg  <= out_order_next;
    end

    // checks
    `ASSERT_AT(a_we_state, clk, rst_n, mem_we |-> (state_reg == S_CHECK || state_reg == S_SWEEP), "memory write outside probe or sweep")
    `ASSERT_NEVER(a_sweep_ready, clk, rst_n, state_reg == S_SWEEP && s_tready, "request taken during sweep")
    `ASSERT_AT(a_sweep_count, clk, rst_n, (state_reg == S_SWEEP && sweep_reply_reg) |-> entry_count_reg == '0, "count not restarted by clear")
    `ASSERT_AT(a_probe_limit, clk, rst_n, (state_reg == S_CHECK) |-> probe_reg < slot_count, "probe count beyond table size")

endmodule

### rtl/core/ohm_probe.sv
module ohm_probe #(
    parameter int MAX_SLOTS_LOG2 = 8
) (
    input  logic [ohm_pkg::CFG_W-1:0]   size_log2,
    input  logic [ohm_pkg::HASH_W-1:0]  key_hash,
    input  logic [MAX_SLOTS_LOG2-1:0]   bucket,
    input  logic [ohm_pkg::HASH_W-1:0]  hash_run,
    output logic [MAX_SLOTS_LOG2-1:0]   first_bucket,
    output logic [MAX_SLOTS_LOG2-1:0]   next_bucket,
    output logic [MAX_SLOTS_LOG2:0]     slot_count
);
    import ohm_pkg::*;

    localparam int AW = MAX_SLOTS_LOG2;

    logic [LOG2_W-1:0] act_log2;
    logic [AW-1:0]     mask;

    // clamp the configured size into the supported range
    always_comb
    begin
        if (size_log2 < CFG_W'(2))
            act_log2 = LOG2_W'(2);
        else if ({1'b0, size_log2} > LOG2_W'(AW))
            act_log2 = LOG2_W'(AW);
        else
            act_log2 = {1'b0, size_log2};
    end

    // slot count and index mask
    assign slot_count = (AW+1)'(1) << act_log2;
    assign mask       = slot_count[AW-1:0] - AW'(1);

    // first probe and perturbed follow-up probe
    assign first_bucket = key_hash[AW-1:0] & mask;
    assign next_bucket  = (bucket + (bucket << 2) + hash_run[AW-1:0] + AW'(1)) & mask;

endmodule
